/* rtl/linear_prime_sieve_unit_assert.svh */
// ---------------------------------------------------------------------------
// linear prime sieve unit assertion macros
// concurrent assertion wrappers on clk with rst as disable
// ---------------------------------------------------------------------------
`ifndef LINEAR_PRIME_SIEVE_UNIT_ASSERT_SVH
`define LINEAR_PRIME_SIEVE_UNIT_ASSERT_SVH

// same-cycle implication
`define LPS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lps_pkg.sv */
// ---------------------------------------------------------------------------
// lps_pkg
// sizes, microcode format and control program of the linear prime sieve
// ---------------------------------------------------------------------------
package lps_pkg;

  localparam int MAP_DEPTH      = 65536;
  localparam int PRIME_CAPACITY = 8192;

  localparam int MAP_AW      = $clog2(MAP_DEPTH);
  localparam int PL_AW       = $clog2(PRIME_CAPACITY);
  localparam int CNT_W       = $clog2(PRIME_CAPACITY + 1);
  localparam int NUM_W       = 16;
  localparam int COUNT_OUT_W = 14;
  localparam int EPOCH_W     = 4;
  localparam int UPC_W       = 4;

  localparam logic [NUM_W-1:0] LIMIT_RESET = 16'hFFFF;
  localparam logic [NUM_W-1:0] LIMIT_MIN   = 16'd2;

  // register index decoded from paddr[2]
  localparam logic REG_LIMIT = 1'b0;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_RESTART,
    OP_CHECK,
    OP_CLASS,
    OP_LREAD,
    OP_MUL,
    OP_MARK,
    OP_FINISH,
    OP_HOLD,
    OP_CLR,
    OP_CLR_END
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_NEED_CLEAR,
    C_DONE,
    C_LIST_END,
    C_PROD_OVER,
    C_NOT_HIT,
    C_OUT_FREE,
    C_CLR_MORE,
    C_BOOT
  } cond_t;

  typedef logic [UPC_W-1:0] upc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic accept;
  } ctrl_t;

  typedef struct packed {
    logic need_clear;
    logic done;
    logic list_end;
    logic prod_over;
    logic not_hit;
    logic out_free;
    logic clr_more;
    logic boot;
  } stat_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [NUM_W-1:0]   spf;
  } map_word_t;

  localparam upc_t U_WAIT    = 4'd0;
  localparam upc_t U_RESTART = 4'd1;
  localparam upc_t U_CHECK   = 4'd2;
  localparam upc_t U_CLASS   = 4'd3;
  localparam upc_t U_LOOP    = 4'd4;
  localparam upc_t U_MUL     = 4'd5;
  localparam upc_t U_OVER    = 4'd6;
  localparam upc_t U_MARK    = 4'd7;
  localparam upc_t U_FIN     = 4'd8;
  localparam upc_t U_FIN_W   = 4'd9;
  localparam upc_t U_HOLD    = 4'd10;
  localparam upc_t U_HOLD_W  = 4'd11;
  localparam upc_t U_CLR     = 4'd12;
  localparam upc_t U_CLR_END = 4'd13;
  localparam upc_t U_CLR_RET = 4'd14;

  // control program: jump to target when cond holds, else fall through
  function automatic uword_t ucode(input upc_t a);
    uword_t w;
    case (a)
      U_WAIT:    w = '{op: OP_ACCEPT,  cond: C_NO_ACCEPT,  target: U_WAIT};
      U_RESTART: w = '{op: OP_RESTART, cond: C_NEED_CLEAR, target: U_CLR};
      U_CHECK:   w = '{op: OP_CHECK,   cond: C_DONE,       target: U_HOLD};
      U_CLASS:   w = '{op: OP_CLASS,   cond: C_NEVER,      target: U_WAIT};
      U_LOOP:    w = '{op: OP_LREAD,   cond: C_LIST_END,   target: U_FIN};
      U_MUL:     w = '{op: OP_MUL,     cond: C_NEVER,      target: U_WAIT};
      U_OVER:    w = '{op: OP_NONE,    cond: C_PROD_OVER,  target: U_FIN};
      U_MARK:    w = '{op: OP_MARK,    cond: C_NOT_HIT,    target: U_LOOP};
      U_FIN:     w = '{op: OP_FINISH,  cond: C_OUT_FREE,   target: U_WAIT};
      U_FIN_W:   w = '{op: OP_NONE,    cond: C_ALWAYS,     target: U_FIN};
      U_HOLD:    w = '{op: OP_HOLD,    cond: C_OUT_FREE,   target: U_WAIT};
      U_HOLD_W:  w = '{op: OP_NONE,    cond: C_ALWAYS,     target: U_HOLD};
      U_CLR:     w = '{op: OP_CLR,     cond: C_CLR_MORE,   target: U_CLR};
      U_CLR_END: w = '{op: OP_CLR_END, cond: C_BOOT,       target: U_WAIT};
      U_CLR_RET: w = '{op: OP_NONE,    cond: C_ALWAYS,     target: U_CHECK};
      default:   w = '{op: OP_NONE,    cond: C_ALWAYS,     target: U_WAIT};
    endcase
    return w;
  endfunction

endpackage

/* rtl/lps_seq.sv */
// ---------------------------------------------------------------------------
// lps_seq
// microcode step counter with conditional jumps over the control program
// ---------------------------------------------------------------------------
module lps_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           step_valid,
  input  lps_pkg::stat_t stat,
  output lps_pkg::ctrl_t ctrl,
  output logic           step_stall
);
  import lps_pkg::*;

  upc_t   pc;
  upc_t   pc_next;
  uword_t uw;
  logic   take;

  always_comb uw = ucode(pc);

  always_comb begin
    case (uw.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_ACCEPT:  take = !step_valid;
      C_NEED_CLEAR: take = stat.need_clear;
      C_DONE:       take = stat.done;
      C_LIST_END:   take = stat.list_end;
      C_PROD_OVER:  take = stat.prod_over;
      C_NOT_HIT:    take = stat.not_hit;
      C_OUT_FREE:   take = stat.out_free;
      C_CLR_MORE:   take = stat.clr_more;
      C_BOOT:       take = stat.boot;
      default:      take = 1'b0;
    endcase
    pc_next = take ? uw.target : pc + 1'b1;
  end

  // reset starts in the map clearing routine
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= U_CLR;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctrl.op     = uw.op;
  assign ctrl.accept = (uw.op == OP_ACCEPT) && step_valid;
  assign step_stall  = (uw.op != OP_ACCEPT);

endmodule

/* rtl/lps_datapath.sv */
// ---------------------------------------------------------------------------
// lps_datapath
// sieve registers, composite map, prime list, multiplier and result register
// ---------------------------------------------------------------------------
module lps_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  lps_pkg::ctrl_t                   ctrl,
  input  logic                             restart,
  input  logic [lps_pkg::NUM_W-1:0]        lim,
  input  logic                             result_stall,
  output lps_pkg::stat_t                   stat,
  output logic                             result_valid,
  output logic [lps_pkg::NUM_W-1:0]        number,
  output logic                             is_prime,
  output logic [lps_pkg::COUNT_OUT_W-1:0]  prime_count,
  output logic                             last
);
  import lps_pkg::*;

  // map entry is composite when its epoch matches; it also keeps the
  // smallest prime factor, which ends the marking walk
  map_word_t map_mem [MAP_DEPTH];
  logic [NUM_W-1:0] list_mem [PRIME_CAPACITY];

  map_word_t          map_q;
  map_word_t          map_wdata;
  logic               map_we;
  logic [MAP_AW-1:0]  map_waddr;
  logic [MAP_AW-1:0]  map_raddr;
  logic [NUM_W-1:0]   list_q;
  logic               list_we;

  logic               restart_r;
  logic [NUM_W-1:0]   cur;
  logic [NUM_W-1:0]   cur_inc;
  logic [NUM_W-1:0]   n;
  logic               n_in_map;
  logic [NUM_W-1:0]   spf_tgt;
  logic               prime_r;
  logic [CNT_W-1:0]   found;
  logic [CNT_W-1:0]   j;
  logic [NUM_W-1:0]   p;
  logic [31:0]        prod;
  logic [EPOCH_W-1:0] epoch;
  logic               boot;
  logic [MAP_AW-1:0]  clr_addr;
  logic [NUM_W-1:0]   held_num;
  logic               held_prime;
  logic [CNT_W-1:0]   held_cnt;

  logic               done;
  logic               composite;
  logic               out_free;

  always_comb begin
    cur_inc   = cur + 1'b1;
    done      = (cur >= lim);
    composite = n_in_map && (map_q.epoch == epoch);
    out_free  = !result_valid || !result_stall;
    map_raddr = MAP_AW'(cur_inc);
    list_we   = (ctrl.op == OP_CLASS) && !composite && (32'(found) < PRIME_CAPACITY);
  end

  always_comb begin
    map_we    = 1'b0;
    map_waddr = clr_addr;
    map_wdata = '0;
    case (ctrl.op)
      OP_CLR: begin
        map_we = 1'b1;
      end
      OP_MARK: begin
        map_we          = (prod < 32'(MAP_DEPTH));
        map_waddr       = MAP_AW'(prod);
        map_wdata.epoch = epoch;
        map_wdata.spf   = p;
      end
      default: begin
        map_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    stat.need_clear = restart_r && (epoch == '1);
    stat.done       = done;
    stat.list_end   = (j >= found);
    stat.prod_over  = (prod > 32'(lim));
    stat.not_hit    = (p != spf_tgt);
    stat.out_free   = out_free;
    stat.clr_more   = (clr_addr != MAP_AW'(MAP_DEPTH - 1));
    stat.boot       = boot;
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_q <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[found[PL_AW-1:0]] <= n;
    end
    list_q <= list_mem[j[PL_AW-1:0]];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      found        <= '0;
      cur          <= NUM_W'(1);
      epoch        <= '0;
      boot         <= 1'b1;
      clr_addr     <= '0;
      held_num     <= '0;
      held_prime   <= 1'b0;
      held_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (ctrl.op)
        OP_RESTART: begin
          if (restart_r) begin
            found <= '0;
            cur   <= NUM_W'(1);
            if (epoch != '1) begin
              epoch <= epoch + 1'b1;
            end
          end
        end
        OP_CHECK: begin
          if (!done) begin
            cur <= cur_inc;
          end
        end
        OP_CLASS: begin
          if (list_we) begin
            found <= found + 1'b1;
          end
        end
        OP_CLR: begin
          clr_addr <= clr_addr + 1'b1;
        end
        OP_CLR_END: begin
          clr_addr <= '0;
          epoch    <= EPOCH_W'(1);
          boot     <= 1'b0;
        end
        OP_FINISH: begin
          if (out_free) begin
            result_valid <= 1'b1;
            held_num     <= n;
            held_prime   <= prime_r;
            held_cnt     <= found;
          end
        end
        OP_HOLD: begin
          if (out_free) begin
            result_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      restart_r <= restart;
    end
    case (ctrl.op)
      OP_CHECK: begin
        n        <= cur_inc;
        n_in_map <= (32'(cur_inc) < MAP_DEPTH);
      end
      OP_CLASS: begin
        prime_r <= !composite;
        spf_tgt <= composite ? map_q.spf : n;
        j       <= '0;
      end
      OP_MUL: begin
        p    <= list_q;
        prod <= n * list_q;
      end
      OP_MARK: begin
        j <= j + 1'b1;
      end
      OP_FINISH: begin
        if (out_free) begin
          number      <= n;
          is_prime    <= prime_r;
          prime_count <= COUNT_OUT_W'(found);
          last        <= (n == lim);
        end
      end
      OP_HOLD: begin
        if (out_free) begin
          number      <= held_num;
          is_prime    <= held_prime;
          prime_count <= COUNT_OUT_W'(held_cnt);
          last        <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/linear_prime_sieve_unit.sv */
// ---------------------------------------------------------------------------
// linear_prime_sieve_unit
// linear (euler) prime sieve driven by a microcoded sequencer
// ---------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  -------   -----------------------   -----------------------------------
//  step      step_valid / step_stall   restart
//  result    result_valid / result_    number, is_prime, prime_count, last
//            stall
//  config    apb psel/penable/pwrite   limit at byte 0 (paddr[2] selects)
//
//  per step beat the marking walk visits listed primes up to the smallest
//    factor, to the end of the list or until the product passes the limit;
//    one multiply and one map write per walk iteration, the write on the
//    single map write port
//  once the limit is reached a step beat repeats the last result with
//    last set
//  after reset a clearing pass sweeps the map with step_stall high; a
//    restart reuses the map under a new epoch and runs the same pass only
//    on every 15th restart
//  the result register holds a beat under result_stall while the next
//    step beat is already taken
// ---------------------------------------------------------------------------
module linear_prime_sieve_unit (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // step channel
  input  logic                             step_valid,
  output logic                             step_stall,
  input  logic                             restart,
  // result channel
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [lps_pkg::NUM_W-1:0]        number,
  output logic                             is_prime,
  output logic [lps_pkg::COUNT_OUT_W-1:0]  prime_count,
  output logic                             last
);
  import lps_pkg::*;

  logic [NUM_W-1:0] limit;
  logic [NUM_W-1:0] lim;
  ctrl_t            ctrl;
  stat_t            stat;

  // register file: one limit register, write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LIMIT)) begin
      limit <= pwdata[NUM_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LIMIT) ? 32'(limit) : '0;

  // limits below two behave as two
  assign lim = (limit < LIMIT_MIN) ? LIMIT_MIN : limit;

  // program counter and microcode table
  lps_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .step_valid (step_valid),
    .stat       (stat),
    .ctrl       (ctrl),
    .step_stall (step_stall)
  );

  // map, prime list, multiplier and result register
  lps_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .restart      (restart),
    .lim          (lim),
    .result_stall (result_stall),
    .stat         (stat),
    .result_valid (result_valid),
    .number       (number),
    .is_prime     (is_prime),
    .prime_count  (prime_count),
    .last         (last)
  );

endmodule

/* rtl/lps_checker.sv */
// ---------------------------------------------------------------------------
// lps_checker
// port-level checks of the linear prime sieve unit, bound to the top level
// ---------------------------------------------------------------------------
`include "linear_prime_sieve_unit_assert.svh"

module lps_checker (
  input logic        clk,
  input logic        rst,
  input logic        step_valid,
  input logic        step_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [15:0] number,
  input logic        is_prime,
  input logic [13:0] prime_count
);

  // a stalled result beat stays put
  `LPS_ASSERT_NXT(a_result_hold, result_valid && result_stall,
    result_valid && $stable(number) && $stable(prime_count), "result beat changed under stall")

  // the sequencer leaves its wait step once a step beat is taken
  `LPS_ASSERT_NXT(a_busy_after_step, step_valid && !step_stall,
    step_stall, "step taken while still working")

  // two is always the first prime
  `LPS_ASSERT_IMP(a_two_first, result_valid && (number == 16'd2),
    is_prime && (prime_count == 14'd1), "wrong result for two")

  // every result follows at least the prime two, and four is the least composite
  `LPS_ASSERT_IMP(a_result_sane, result_valid,
    (prime_count != 14'd0) && (is_prime || (number >= 16'd4)), "implausible result")

endmodule

bind linear_prime_sieve_unit lps_checker u_lps_checker (.*);
